>>> design/lpfs_pkg.sv
package lpfs_pkg;

    localparam int BUFFER_DEPTH = 256;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    // store depth as a 9-bit value, for compares against 9-bit positions
    localparam logic [8:0] DEPTH_LIMIT = 9'(BUFFER_DEPTH);

    typedef enum logic [1:0] {
        KIND_BUS_BYTE  = 2'd0,
        KIND_BUS_READ  = 2'd1,
        KIND_HOST_LOAD = 2'd2,
        KIND_HOST_READ = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_RX_WR = 3'd1,
        OP_RX_RD = 3'd2,
        OP_TX_WR = 3'd3,
        OP_TX_RD = 3'd4
    } t_code;

    // one classified word: memory action plus the fields known up front
    typedef struct packed {
        t_code               code;
        logic [ADDR_W-1:0]   addr;
        logic [7:0]          data;
        logic                frame_done;
        logic [7:0]          rx_length;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_push;

endpackage

>>> design/length_prefixed_frame_slave.sv
// Channel   Direction  Handshake          Fields
// input     in         i_valid / o_stall  i_kind i_first i_value i_index i_count
// result    out        o_valid / i_stall  o_tx_byte o_frame_done o_rx_length o_read_data
//
// One word per cycle sustained while no stall holds the flow; each word is written
// to the queue at accept, popped into s1 as its RAM read is issued, then loaded
// into the output register.
// The front updates positions and lengths at accept; each word does at most one
// access to the receive or transmit RAM in the back.
// i_rst_n is synchronous; store contents are not cleared.
// A 4-word queue parts front and back: o_stall rises only when it is full.
module length_prefixed_frame_slave (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [1:0] i_kind,
    input  logic       i_first,
    input  logic [7:0] i_value,
    input  logic [7:0] i_index,
    input  logic [7:0] i_count,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_tx_byte,
    output logic       o_frame_done,
    output logic [7:0] o_rx_length,
    output logic [7:0] o_read_data
);
    import lpfs_pkg::*;

    t_push push;
    t_op   head;
    logic  full;
    logic  empty;
    logic  pop;

    lpfs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_kind  (i_kind),
        .i_first (i_first),
        .i_value (i_value),
        .i_index (i_index),
        .i_count (i_count),
        .i_full  (full),
        .o_push  (push)
    );

    lpfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_head  (head)
    );

    lpfs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (empty),
        .i_head       (head),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_tx_byte    (o_tx_byte),
        .o_frame_done (o_frame_done),
        .o_rx_length  (o_rx_length),
        .o_read_data  (o_read_data)
    );

    assign o_stall = full;

endmodule

>>> design/lpfs_ram.sv
module lpfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/lpfs_front.sv
module lpfs_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [1:0]    i_kind,
    input  logic          i_first,
    input  logic [7:0]    i_value,
    input  logic [7:0]    i_index,
    input  logic [7:0]    i_count,
    input  logic          i_full,
    output lpfs_pkg::t_push o_push
);
    import lpfs_pkg::*;

    logic [7:0] r_rx_pos,    n_rx_pos;
    logic [7:0] r_rx_len,    n_rx_len;
    logic [8:0] r_tx_pos,    n_tx_pos;
    logic [8:0] r_tx_total,  n_tx_total;
    logic [7:0] r_tx_header, n_tx_header;
    logic       accept;
    logic [7:0] rx_pos_inc;
    logic [8:0] load_slot;
    t_op        op;

    assign accept     = i_valid && !i_full;
    assign rx_pos_inc = r_rx_pos + 8'd1;
    assign load_slot  = {1'b0, i_index} + 9'd1;

    always_comb begin
        n_rx_pos      = r_rx_pos;
        n_rx_len      = r_rx_len;
        n_tx_pos      = r_tx_pos;
        n_tx_total    = r_tx_total;
        n_tx_header   = r_tx_header;
        op.code       = OP_NONE;
        op.addr       = '0;
        op.data       = '0;
        op.frame_done = 1'b0;
        case (t_kind'(i_kind))
            KIND_BUS_BYTE: begin
                if (i_first) begin
                    n_rx_len = i_value;
                    n_rx_pos = '0;
                end else if (r_rx_pos < r_rx_len) begin
                    if ({1'b0, r_rx_pos} < DEPTH_LIMIT) begin
                        op.code = OP_RX_WR;
                        op.addr = r_rx_pos[ADDR_W-1:0];
                        op.data = i_value;
                    end
                    n_rx_pos = rx_pos_inc;
                    if (rx_pos_inc == r_rx_len) begin
                        // frame complete: drop the transmit frame
                        n_tx_total    = '0;
                        n_tx_header   = '0;
                        n_tx_pos      = '0;
                        op.frame_done = 1'b1;
                    end
                end
            end
            KIND_BUS_READ: begin
                if (r_tx_pos < r_tx_total) begin
                    if (r_tx_pos == 9'd0) begin
                        op.data = r_tx_header;
                    end else if (r_tx_pos < DEPTH_LIMIT) begin
                        op.code = OP_TX_RD;
                        op.addr = r_tx_pos[ADDR_W-1:0];
                    end
                    n_tx_pos = r_tx_pos + 9'd1;
                end
            end
            KIND_HOST_LOAD: begin
                n_tx_header = i_count;
                n_tx_total  = {1'b0, i_count} + 9'd1;
                if (i_index < i_count && load_slot < DEPTH_LIMIT) begin
                    op.code = OP_TX_WR;
                    op.addr = load_slot[ADDR_W-1:0];
                    op.data = i_value;
                end
            end
            KIND_HOST_READ: begin
                if (i_index < r_rx_len && {1'b0, i_index} < DEPTH_LIMIT) begin
                    op.code = OP_RX_RD;
                    op.addr = i_index[ADDR_W-1:0];
                end
            end
            default: begin
            end
        endcase
        op.rx_length = n_rx_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rx_pos    <= '0;
            r_rx_len    <= '0;
            r_tx_pos    <= '0;
            r_tx_total  <= '0;
            r_tx_header <= '0;
        end else if (accept) begin
            r_rx_pos    <= n_rx_pos;
            r_rx_len    <= n_rx_len;
            r_tx_pos    <= n_tx_pos;
            r_tx_total  <= n_tx_total;
            r_tx_header <= n_tx_header;
        end
    end

    assign o_push.valid = accept;
    assign o_push.op    = op;

endmodule

>>> design/lpfs_queue.sv
module lpfs_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lpfs_pkg::t_push i_push,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output lpfs_pkg::t_op   o_head
);
    import lpfs_pkg::*;

    t_op               r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_fill;
    logic              do_pop;

    assign o_full  = r_fill == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign o_empty = r_fill == '0;
    assign o_head  = r_slot[r_rd_ptr];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_slot[r_wr_ptr] <= i_push.op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push.valid && !do_pop) begin
                r_fill <= r_fill + (QPTR_W + 1)'(1);
            end else if (do_pop && !i_push.valid) begin
                r_fill <= r_fill - (QPTR_W + 1)'(1);
            end
        end
    end

endmodule

>>> design/lpfs_back.sv
module lpfs_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  lpfs_pkg::t_op i_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_stall,
    output logic [7:0]    o_tx_byte,
    output logic          o_frame_done,
    output logic [7:0]    o_rx_length,
    output logic [7:0]    o_read_data
);
    import lpfs_pkg::*;

    t_op        r_s1;
    logic       r_s1_valid;
    logic       r_out_valid;
    logic [7:0] r_tx_byte;
    logic       r_frame_done;
    logic [7:0] r_rx_length;
    logic [7:0] r_read_data;
    logic       out_free;
    logic       advance;
    logic       pop;
    logic [7:0] rx_rdata;
    logic [7:0] tx_rdata;
    logic [7:0] tx_byte;
    logic [7:0] read_data;

    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_s1_valid && out_free;
    assign pop      = !i_empty && (!r_s1_valid || out_free);

    // RAM read data holds while the word waits in s1
    lpfs_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (pop && i_head.code == OP_RX_WR),
        .i_waddr (i_head.addr),
        .i_wdata (i_head.data),
        .i_re    (pop && i_head.code == OP_RX_RD),
        .i_raddr (i_head.addr),
        .o_rdata (rx_rdata)
    );

    lpfs_ram #(.WIDTH(8), .DEPTH(BUFFER_DEPTH)) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (pop && i_head.code == OP_TX_WR),
        .i_waddr (i_head.addr),
        .i_wdata (i_head.data),
        .i_re    (pop && i_head.code == OP_TX_RD),
        .i_raddr (i_head.addr),
        .o_rdata (tx_rdata)
    );

    always_comb begin
        tx_byte   = '0;
        read_data = '0;
        case (r_s1.code)
            OP_NONE:  tx_byte   = r_s1.data;
            OP_TX_RD: tx_byte   = tx_rdata;
            OP_RX_RD: read_data = rx_rdata;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s1 <= i_head;
        end
        if (advance) begin
            r_tx_byte    <= tx_byte;
            r_frame_done <= r_s1.frame_done;
            r_rx_length  <= r_s1.rx_length;
            r_read_data  <= read_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_s1_valid <= 1'b1;
            end else if (advance) begin
                r_s1_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_pop        = pop;
    assign o_valid      = r_out_valid;
    assign o_tx_byte    = r_tx_byte;
    assign o_frame_done = r_frame_done;
    assign o_rx_length  = r_rx_length;
    assign o_read_data  = r_read_data;

endmodule

>>> design/lpfs_checker.sv
module lpfs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_valid,
    input logic       o_stall,
    input logic [1:0] i_kind,
    input logic       i_first,
    input logic [7:0] i_value,
    input logic [7:0] i_index,
    input logic [7:0] i_count,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_tx_byte,
    input logic       o_frame_done,
    input logic [7:0] o_rx_length,
    input logic [7:0] o_read_data
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_tx_byte) && $stable(o_frame_done)
            && $stable(o_rx_length) && $stable(o_read_data))
        else $error("result word changed while stalled");

    // a frame can only complete against a nonzero header length
    a_done_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_done |-> o_rx_length != 8'd0)
        else $error("frame_done with zero length");

    // frame completion comes from a bus byte, which answers no data
    a_done_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_frame_done |-> o_tx_byte == 8'd0 && o_read_data == 8'd0)
        else $error("frame_done word carries data");

    // a word answers the bus or the host, never both
    a_one_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_tx_byte == 8'd0 || o_read_data == 8'd0)
        else $error("tx_byte and read_data both set");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("output valid or stall after reset");

endmodule

bind length_prefixed_frame_slave lpfs_checker u_lpfs_checker (.*);

>>> verif/lpfs_frame_checker.sv
module lpfs_frame_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [1:0] i_kind,
    input  logic       i_first,
    input  logic [7:0] i_value,
    input  logic [7:0] i_index,
    input  logic [7:0] i_count,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_tx_byte,
    input  logic       i_frame_done,
    input  logic [7:0] i_rx_length,
    input  logic [7:0] i_read_data,
    output int         o_fail_count,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import lpfs_pkg::*;

    typedef struct packed {
        logic [7:0] tx_byte;
        logic       frame_done;
        logic [7:0] rx_length;
        logic [7:0] read_data;
    } t_frame_answer;

    logic [7:0] rx_mem [BUFFER_DEPTH];
    logic [7:0] tx_mem [BUFFER_DEPTH];
    logic [7:0] rx_pos;
    logic [7:0] rx_len;
    logic [8:0] tx_pos;
    logic [8:0] tx_total;

    t_frame_answer answers_due [$];
    t_frame_answer want;
    int            fail_count = 0;

    // Advances the frame state by one word and returns the answer it produces.
    function automatic t_frame_answer predict_answer(t_kind kind, logic first,
                                                     logic [7:0] value, logic [7:0] index,
                                                     logic [7:0] count);
        t_frame_answer ans;
        ans = '0;
        case (kind)
            KIND_BUS_BYTE: begin
                if (first) begin
                    rx_len = value;
                    rx_pos = '0;
                end else if (rx_pos < rx_len) begin
                    if ({1'b0, rx_pos} < DEPTH_LIMIT)
                        rx_mem[rx_pos] = value;
                    rx_pos = rx_pos + 8'd1;
                    // last body byte: transmit side starts over
                    if (rx_pos == rx_len) begin
                        tx_total       = '0;
                        tx_mem[0]      = '0;
                        tx_pos         = '0;
                        ans.frame_done = 1'b1;
                    end
                end
            end
            KIND_BUS_READ: begin
                if (tx_pos < tx_total) begin
                    if (tx_pos < DEPTH_LIMIT)
                        ans.tx_byte = tx_mem[tx_pos[7:0]];
                    tx_pos = tx_pos + 9'd1;
                end
            end
            KIND_HOST_LOAD: begin
                tx_mem[0] = count;
                tx_total  = {1'b0, count} + 9'd1;
                if (index < count && {1'b0, index} + 9'd1 < DEPTH_LIMIT)
                    tx_mem[index + 8'd1] = value;
            end
            default: begin
                if (index < rx_len && {1'b0, index} < DEPTH_LIMIT)
                    ans.read_data = rx_mem[index];
            end
        endcase
        ans.rx_length = rx_len;
        return ans;
    endfunction

    task automatic check_field(input string name, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rx_pos   = '0;
            rx_len   = '0;
            tx_pos   = '0;
            tx_total = '0;
            answers_due.delete();
        end else begin
            if (i_in_valid && !i_in_stall)
                answers_due.push_back(predict_answer(t_kind'(i_kind), i_first, i_value,
                                                     i_index, i_count));
            if (i_out_valid && !i_out_stall) begin
                if (answers_due.size() == 0) begin
                    $error("unexpected result word: tx_byte %0d rx_length %0d read_data %0d",
                           i_tx_byte, i_rx_length, i_read_data);
                    fail_count++;
                end else begin
                    want = answers_due.pop_front();
                    check_field("tx_byte", want.tx_byte, i_tx_byte);
                    check_field("frame_done", {7'd0, want.frame_done}, {7'd0, i_frame_done});
                    check_field("rx_length", want.rx_length, i_rx_length);
                    check_field("read_data", want.read_data, i_read_data);
                end
            end
        end
        o_fail_count = fail_count;
        o_pending    = answers_due.size();
    end

endmodule

>>> verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lpfs_pkg::*;

    localparam int PLAN_WORDS = 775;

    logic       i_clk;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [1:0] i_kind  = KIND_BUS_BYTE;
    logic       i_first = 1'b0;
    logic [7:0] i_value = '0;
    logic [7:0] i_index = '0;
    logic [7:0] i_count = '0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [7:0] o_tx_byte;
    logic       o_frame_done;
    logic [7:0] o_rx_length;
    logic [7:0] o_read_data;

    int fail_count;
    int pending;

    int sent        = 0;
    int send_idle   = 31;
    int recv_stall  = 66;

    // what the stimulus knows of the block, only to keep reads on written entries
    bit rx_filled [BUFFER_DEPTH];
    bit tx_filled [BUFFER_DEPTH];
    int gen_rx_len   = 0;
    int gen_rx_pos   = 0;
    int gen_tx_pos   = 0;
    int gen_tx_total = 0;

    length_prefixed_frame_slave i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_kind       (i_kind),
        .i_first      (i_first),
        .i_value      (i_value),
        .i_index      (i_index),
        .i_count      (i_count),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_tx_byte    (o_tx_byte),
        .o_frame_done (o_frame_done),
        .o_rx_length  (o_rx_length),
        .o_read_data  (o_read_data)
    );

    lpfs_frame_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_kind       (i_kind),
        .i_first      (i_first),
        .i_value      (i_value),
        .i_index      (i_index),
        .i_count      (i_count),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_tx_byte    (o_tx_byte),
        .i_frame_done (o_frame_done),
        .i_rx_length  (o_rx_length),
        .i_read_data  (o_read_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(0, 99) < recv_stall);
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Called at a rising edge; returns at the edge the word was accepted.
    task automatic send_word(input t_kind kind, input logic first, input logic [7:0] value,
                             input logic [7:0] index, input logic [7:0] count);
        int tries;
        int phase;
        tries = 0;
        phase = sent * 3 / PLAN_WORDS;
        send_idle  = (phase == 0) ? 31 : (phase == 1) ? 66 : 0;
        recv_stall = (phase == 0) ? 66 : (phase == 1) ? 31 : 0;

        if (kind == KIND_HOST_READ) begin
            while (index < gen_rx_len && !rx_filled[index] && tries < 8) begin
                index = 8'($urandom_range(0, gen_rx_len - 1));
                tries++;
            end
            if (index < gen_rx_len && !rx_filled[index])
                index = 8'hFF;
        end else if (kind == KIND_BUS_READ && gen_tx_pos < gen_tx_total &&
                     !tx_filled[gen_tx_pos]) begin
            // entry due next was never loaded: load it instead, same length
            kind  = KIND_HOST_LOAD;
            index = 8'(gen_tx_pos - 1);
            count = 8'(gen_tx_total - 1);
        end

        case (kind)
            KIND_BUS_BYTE: begin
                if (first) begin
                    gen_rx_len = value;
                    gen_rx_pos = 0;
                end else if (gen_rx_pos < gen_rx_len) begin
                    rx_filled[gen_rx_pos] = 1'b1;
                    gen_rx_pos++;
                    if (gen_rx_pos == gen_rx_len) begin
                        gen_tx_total = 0;
                        gen_tx_pos   = 0;
                        tx_filled[0] = 1'b1;
                    end
                end
            end
            KIND_BUS_READ: begin
                if (gen_tx_pos < gen_tx_total)
                    gen_tx_pos++;
            end
            KIND_HOST_LOAD: begin
                tx_filled[0] = 1'b1;
                gen_tx_total = count + 1;
                if (index < count)
                    tx_filled[index + 1] = 1'b1;
            end
            default: ;
        endcase

        while ($urandom_range(0, 99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind  <= kind;
        i_first <= first;
        i_value <= value;
        i_index <= index;
        i_count <= count;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        sent++;
    endtask

    task automatic send_bus_reads(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_word(KIND_BUS_READ, 1'($urandom_range(0, 1)), any_byte(), any_byte(),
                      any_byte());
    endtask

    task automatic send_host_reads(input int n);
        int i;
        int idx;
        for (i = 0; i < n; i++) begin
            idx = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255)
                                              : $urandom_range(0, gen_rx_len);
            send_word(KIND_HOST_READ, 1'($urandom_range(0, 1)), any_byte(), 8'(idx),
                      any_byte());
        end
    endtask

    task automatic send_noise(input int n);
        int i;
        for (i = 0; i < n; i++)
            send_word(t_kind'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), any_byte(),
                      any_byte(), any_byte());
    endtask

    task automatic send_rx_frame();
        int len;
        int body;
        int shape;
        int i;
        shape = $urandom_range(0, 39);
        if (shape == 0)
            len = 0;
        else if (shape == 1)
            len = $urandom_range(64, 255);
        else
            len = $urandom_range(1, 12);
        body  = len;
        shape = $urandom_range(0, 7);
        if (shape == 0)
            body = $urandom_range(0, len);        // cut short by the next header
        else if (shape == 1)
            body = len + $urandom_range(1, 3);    // trailing words ignored
        send_word(KIND_BUS_BYTE, 1'b1, 8'(len), any_byte(), any_byte());
        for (i = 0; i < body; i++) begin
            if ($urandom_range(0, 5) == 0)
                send_word($urandom_range(0, 1) ? KIND_BUS_READ : KIND_HOST_READ,
                          1'($urandom_range(0, 1)), any_byte(), any_byte(), any_byte());
            send_word(KIND_BUS_BYTE, 1'b0, any_byte(), any_byte(), any_byte());
        end
        if ($urandom_range(0, 1))
            send_host_reads($urandom_range(1, 4));
    endtask

    task automatic send_tx_load();
        int cnt;
        int loads;
        int i;
        int idx;
        cnt   = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 255) : $urandom_range(0, 16);
        loads = (cnt > 16) ? 16 : cnt;
        for (i = 0; i < loads; i++) begin
            idx = (cnt > 16) ? $urandom_range(0, cnt - 1) : i;
            send_word(KIND_HOST_LOAD, 1'($urandom_range(0, 1)), any_byte(), 8'(idx), 8'(cnt));
        end
        // index at or past the length: header only, body word dropped
        if (cnt == 0 || $urandom_range(0, 5) == 0)
            send_word(KIND_HOST_LOAD, 1'($urandom_range(0, 1)), any_byte(),
                      8'($urandom_range(cnt, 255)), 8'(cnt));
        if ($urandom_range(0, 2) != 0)
            send_bus_reads(loads + $urandom_range(1, 3));
    endtask

    initial begin
        int pick;
        int drain;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero-length header: body words ignored, nothing to read
        send_word(KIND_BUS_BYTE, 1'b1, 8'h00, 8'h00, 8'h00);
        send_word(KIND_BUS_BYTE, 1'b0, 8'h5A, 8'h00, 8'h00);
        send_word(KIND_HOST_READ, 1'b0, 8'h00, 8'h00, 8'h00);
        send_word(KIND_BUS_READ, 1'b0, 8'h00, 8'h00, 8'h00);
        // empty transmit frame: header then used up
        send_word(KIND_HOST_LOAD, 1'b0, 8'hFF, 8'h00, 8'h00);
        send_word(KIND_BUS_READ, 1'b0, 8'h00, 8'h00, 8'h00);
        send_word(KIND_BUS_READ, 1'b0, 8'h00, 8'h00, 8'h00);
        // longest transmit frame, last entry, then an index past the length
        send_word(KIND_HOST_LOAD, 1'b0, 8'hA5, 8'hFE, 8'hFF);
        send_word(KIND_HOST_LOAD, 1'b1, 8'h3C, 8'hFF, 8'hFF);
        // three-word frame plus one extra word
        send_word(KIND_BUS_BYTE, 1'b1, 8'h03, 8'h00, 8'h00);
        send_word(KIND_BUS_BYTE, 1'b0, 8'hFF, 8'hFF, 8'hFF);
        send_word(KIND_BUS_BYTE, 1'b0, 8'h00, 8'h00, 8'h00);
        send_word(KIND_BUS_BYTE, 1'b0, 8'h80, 8'h01, 8'h01);
        send_word(KIND_BUS_BYTE, 1'b0, 8'h77, 8'h00, 8'h00);
        send_word(KIND_HOST_READ, 1'b0, 8'h00, 8'h00, 8'h00);
        send_word(KIND_HOST_READ, 1'b0, 8'h00, 8'h02, 8'h00);
        send_word(KIND_HOST_READ, 1'b0, 8'h00, 8'h03, 8'h00);
        send_word(KIND_HOST_READ, 1'b1, 8'hFF, 8'hFF, 8'hFF);
        // two-word transmit frame read out and past its end
        send_word(KIND_HOST_LOAD, 1'b0, 8'h11, 8'h00, 8'h02);
        send_word(KIND_HOST_LOAD, 1'b0, 8'h22, 8'h01, 8'h02);
        send_bus_reads(4);
        send_word(KIND_BUS_BYTE, 1'b1, 8'hFF, 8'hFF, 8'hFF);

        while (sent < PLAN_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                send_rx_frame();
            else if (pick < 65)
                send_tx_load();
            else if (pick < 82)
                send_bus_reads($urandom_range(1, 10));
            else if (pick < 94)
                send_host_reads($urandom_range(1, 6));
            else
                send_noise($urandom_range(1, 4));
        end
        i_valid <= 1'b0;

        drain = 0;
        while (pending != 0 && drain < 2000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (8) @(posedge i_clk);
        if (pending != 0)
            $error("%0d result words never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
design/lpfs_pkg.sv
design/lpfs_ram.sv
design/lpfs_front.sv
design/lpfs_queue.sv
design/lpfs_back.sv
design/length_prefixed_frame_slave.sv
design/lpfs_checker.sv
verif/lpfs_frame_checker.sv
verif/tb.sv
